// ===== rtl/core/whg_pkg.sv =====
// Shared widths, codes and constants of the wrapped hex grid geometry unit.
`default_nettype none

package whg_pkg;

    // Field widths
    localparam int COORD_W  = 10;
    localparam int CFG_W    = 11;
    localparam int DIR_W    = 3;
    localparam int RADIUS_W = 10;
    localparam int DIST_W   = 11;
    localparam int HEAD_W   = 3;
    localparam int COUNT_W  = 22;
    localparam int ACT_W    = 2;
    localparam int CFG_ADDR_W = 1;

    // Stream widths
    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 56;

    // Default map limit and register reset value
    localparam int MAX_SIDE_DEF = 1024;
    localparam logic [CFG_W-1:0] MAP_RESET = 11'd1024;

    // Register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_MAP_WIDTH  = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_MAP_HEIGHT = 1'b1;

    // Actions
    localparam logic [ACT_W-1:0] ACT_NEIGHBOUR = 2'd0;
    localparam logic [ACT_W-1:0] ACT_DISTANCE  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_HEADING   = 2'd2;
    localparam logic [ACT_W-1:0] ACT_COUNT     = 2'd3;

    // Step directions
    localparam logic [DIR_W-1:0] DIR_W_  = 3'd0;
    localparam logic [DIR_W-1:0] DIR_NW  = 3'd1;
    localparam logic [DIR_W-1:0] DIR_NE  = 3'd2;
    localparam logic [DIR_W-1:0] DIR_E   = 3'd3;
    localparam logic [DIR_W-1:0] DIR_SE  = 3'd4;

    // Headings
    localparam logic [HEAD_W-1:0] HEAD_N  = 3'd0;
    localparam logic [HEAD_W-1:0] HEAD_NE = 3'd1;
    localparam logic [HEAD_W-1:0] HEAD_SE = 3'd2;
    localparam logic [HEAD_W-1:0] HEAD_S  = 3'd3;
    localparam logic [HEAD_W-1:0] HEAD_SW = 3'd4;
    localparam logic [HEAD_W-1:0] HEAD_NW = 3'd5;

    // Fixed-point slope of the 60 degree split: dy * 1000 against dx * 1732
    localparam int HEAD_DEN   = 1000;
    localparam int HEAD_NUM   = 1732;
    localparam int HEAD_K_W   = 11;

    // Per-item fields that ride along the pipeline
    typedef struct packed {
        logic [ACT_W-1:0]    action;
        logic [DIR_W-1:0]    step_dir;
        logic [RADIUS_W-1:0] radius;
        logic                include_center;
    } t_side;

endpackage

`default_nettype wire

// ===== rtl/core/wrapped_hex_grid_geometry.sv =====
// Top level of the wrapped hex grid geometry unit: neighbour, distance, heading, cell count.
// Each result passes through five register stages: input, two reduction stages, geometry and output.
// Throughput: one item per cycle; every stage has its own valid bit and stalls only
// when the stage behind it is full and cannot move on.
// The coordinate reduction modulo the map size takes two stages of restoring steps.
// Reset (i_rst_n low, synchronous) empties the pipeline and sets both map sizes to 1024.
`default_nettype none

module wrapped_hex_grid_geometry
    import whg_pkg::*;
#(
    parameter int MAX_SIDE = MAX_SIDE_DEF
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,

    // Configuration write port
    input  wire                    i_cfg_we,
    input  wire [CFG_ADDR_W-1:0]   i_cfg_addr,
    input  wire [CFG_W-1:0]        i_cfg_data,

    // Input stream
    input  wire                    s_axis_tvalid,
    output logic                   s_axis_tready,
    // tdata from bit 0: first_x[10], first_y[10], second_x[10], second_y[10],
    // step_dir[3], radius[10], include_center[1], zero padding[2]
    input  wire [S_TDATA_W-1:0]    s_axis_tdata,
    // tuser: action[2]
    input  wire [ACT_W-1:0]        s_axis_tuser,

    // Result stream
    output logic                   m_axis_tvalid,
    input  wire                    m_axis_tready,
    // tdata from bit 0: near_x[10], near_y[10], hex_distance[11], heading[3],
    // cell_count[22]
    output logic [M_TDATA_W-1:0]   m_axis_tdata
);

    // The effective map size never exceeds MAX_SIDE nor the register range.
    localparam int EFF_MAX = (MAX_SIDE < 2047) ? MAX_SIDE : 2047;
    localparam int SW      = $clog2(EFF_MAX + 1);
    localparam int TOP_H   = MAX_SIDE - (MAX_SIDE % 2);
    localparam int LO      = COORD_W / 2;
    localparam int HI      = COORD_W - LO;
    localparam int AW      = SW + 2;
    localparam int DW      = SW + 3;
    localparam int PW      = SW + HEAD_K_W;
    localparam int RR_W    = 2 * RADIUS_W + 1;
    localparam int NSTG    = 5;

    // Width: zero reads as one, anything above the limit as the limit.
    function automatic logic [SW-1:0] f_eff_w(input logic [CFG_W-1:0] v);
        logic [SW-1:0] r;
        r = SW'(v);
        if (v == '0) begin
            r = SW'(1);
        end else if (int'(v) > MAX_SIDE) begin
            r = SW'(MAX_SIDE);
        end
        return r;
    endfunction

    // Height: always even, held between two and the even limit.
    function automatic logic [SW-1:0] f_eff_h(input logic [CFG_W-1:0] v);
        logic [CFG_W-1:0] e;
        logic [SW-1:0]    r;
        e = {v[CFG_W-1:1], 1'b0};
        r = SW'(e);
        if (int'(e) > TOP_H) begin
            r = SW'(TOP_H);
        end
        if (int'(e) < 2) begin
            r = SW'(2);
        end
        return r;
    endfunction

    // Map size, stored already clamped
    logic [SW-1:0] r_eff_w;
    logic [SW-1:0] r_eff_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eff_w <= f_eff_w(MAP_RESET);
            r_eff_h <= f_eff_h(MAP_RESET);
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_MAP_WIDTH:  r_eff_w <= f_eff_w(i_cfg_data);
                CFG_MAP_HEIGHT: r_eff_h <= f_eff_h(i_cfg_data);
                default: ;
            endcase
        end
    end

    // Pipeline flow control: a stage takes new data when it is empty or
    // when its own content moves on in the same cycle.
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] rdy;

    always_comb begin
        rdy[NSTG-1] = !r_vld[NSTG-1] || m_axis_tready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            rdy[k] = !r_vld[k] || rdy[k+1];
        end
    end

    assign s_axis_tready = rdy[0];
    assign m_axis_tvalid = r_vld[NSTG-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (rdy[0]) begin
                r_vld[0] <= s_axis_tvalid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Lanes in order: first_x, first_y, second_x, second_y.
    logic [SW-1:0] lane_div [4];
    assign lane_div[0] = r_eff_w;
    assign lane_div[1] = r_eff_h;
    assign lane_div[2] = r_eff_w;
    assign lane_div[3] = r_eff_h;

    // Stage 0: input register
    t_side            r_s0_side;
    logic [COORD_W-1:0] r_s0_crd [4];

    always_ff @(posedge i_clk) begin
        if (rdy[0]) begin
            r_s0_side.action         <= s_axis_tuser;
            r_s0_side.step_dir       <= s_axis_tdata[42:40];
            r_s0_side.radius         <= s_axis_tdata[52:43];
            r_s0_side.include_center <= s_axis_tdata[53];
            r_s0_crd[0]              <= s_axis_tdata[9:0];
            r_s0_crd[1]              <= s_axis_tdata[19:10];
            r_s0_crd[2]              <= s_axis_tdata[29:20];
            r_s0_crd[3]              <= s_axis_tdata[39:30];
        end
    end

    // Stages 1 and 2: coordinate reduction, upper bits first, then lower bits
    t_side          r_s1_side;
    logic [SW-1:0]  r_s1_rem [4];
    logic [LO-1:0]  r_s1_low [4];
    t_side          r_s2_side;
    logic [SW-1:0]  r_s2_crd [4];
    logic [SW-1:0]  n_s1_rem [4];
    logic [SW-1:0]  n_s2_crd [4];

    for (genvar g = 0; g < 4; g++) begin : g_lane
        whg_rem_unit #(
            .SW    (SW),
            .STEPS (HI)
        ) u_rem_hi (
            .i_rem  ('0),
            .i_bits (r_s0_crd[g][COORD_W-1 -: HI]),
            .i_div  (lane_div[g]),
            .o_rem  (n_s1_rem[g])
        );

        whg_rem_unit #(
            .SW    (SW),
            .STEPS (LO)
        ) u_rem_lo (
            .i_rem  (r_s1_rem[g]),
            .i_bits (r_s1_low[g]),
            .i_div  (lane_div[g]),
            .o_rem  (n_s2_crd[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (rdy[1]) begin
            r_s1_side <= r_s0_side;
            for (int i = 0; i < 4; i++) begin
                r_s1_rem[i] <= n_s1_rem[i];
                r_s1_low[i] <= r_s0_crd[i][LO-1:0];
            end
        end
        if (rdy[2]) begin
            r_s2_side <= r_s1_side;
            for (int i = 0; i < 4; i++) begin
                r_s2_crd[i] <= n_s2_crd[i];
            end
        end
    end

    // Stage 3: neighbour, wrapped deltas, heading products, radius product
    logic [SW-1:0] x1, y1, x2, y2;
    assign x1 = r_s2_crd[0];
    assign y1 = r_s2_crd[1];
    assign x2 = r_s2_crd[2];
    assign y2 = r_s2_crd[3];

    logic [COORD_W-1:0] n_s3_nx, n_s3_ny;
    logic [AW-1:0]      n_s3_dxw, n_s3_dyw;
    logic               n_s3_north, n_s3_west;
    logic [PW-1:0]      n_s3_pdy, n_s3_pdx;
    logic [RR_W-1:0]    n_s3_rr;

    // Neighbour with wrap at both edges; odd rows sit half a cell to the right.
    always_comb begin : neighbour
        logic [SW:0] xm, xp, ym, yp;
        logic        odd;
        xm  = (x1 == '0) ? ({1'b0, r_eff_w} - 1'b1) : ({1'b0, x1} - 1'b1);
        xp  = ({1'b0, x1} + 1'b1 == {1'b0, r_eff_w}) ? '0 : ({1'b0, x1} + 1'b1);
        ym  = (y1 == '0) ? ({1'b0, r_eff_h} - 1'b1) : ({1'b0, y1} - 1'b1);
        yp  = ({1'b0, y1} + 1'b1 == {1'b0, r_eff_h}) ? '0 : ({1'b0, y1} + 1'b1);
        odd = y1[0];
        case (r_s2_side.step_dir)
            DIR_W_: begin
                n_s3_nx = COORD_W'(xm);
                n_s3_ny = COORD_W'(y1);
            end
            DIR_NW: begin
                n_s3_nx = odd ? COORD_W'(x1) : COORD_W'(xm);
                n_s3_ny = COORD_W'(ym);
            end
            DIR_NE: begin
                n_s3_nx = odd ? COORD_W'(xp) : COORD_W'(x1);
                n_s3_ny = COORD_W'(ym);
            end
            DIR_E: begin
                n_s3_nx = COORD_W'(xp);
                n_s3_ny = COORD_W'(y1);
            end
            DIR_SE: begin
                n_s3_nx = odd ? COORD_W'(xp) : COORD_W'(x1);
                n_s3_ny = COORD_W'(yp);
            end
            // South-west, and the two unused codes that behave the same
            default: begin
                n_s3_nx = odd ? COORD_W'(x1) : COORD_W'(xm);
                n_s3_ny = COORD_W'(yp);
            end
        endcase
    end

    // Distance in doubled units: rows count two, the row offset counts one.
    always_comb begin : dist_prep
        logic [DW-1:0] dxs;
        logic [AW-1:0] adx, ady, w2, h2;
        dxs = ((DW'(x1) - DW'(x2)) << 1) + DW'(y1[0]) - DW'(y2[0]);
        adx = dxs[DW-1] ? AW'(-dxs) : AW'(dxs);
        ady = (y1 > y2) ? (AW'(y1 - y2) << 1) : (AW'(y2 - y1) << 1);
        w2  = AW'(r_eff_w) << 1;
        h2  = AW'(r_eff_h) << 1;
        n_s3_dyw = (ady > AW'(r_eff_h)) ? (h2 - ady) : ady;
        n_s3_dxw = (adx > AW'(r_eff_w)) ? (w2 - adx) : adx;
    end

    // Heading: take the short way round, which flips the sense of the compare.
    always_comb begin : head_prep
        logic [SW-1:0] dyh, dxh;
        logic          swap_y, swap_x;
        dyh    = (y1 > y2) ? (y1 - y2) : (y2 - y1);
        dxh    = (x1 > x2) ? (x1 - x2) : (x2 - x1);
        swap_y = dyh > (r_eff_h >> 1);
        swap_x = dxh > (r_eff_w >> 1);
        if (swap_y) begin
            dyh = r_eff_h - dyh;
        end
        if (swap_x) begin
            dxh = r_eff_w - dxh;
        end
        n_s3_north = swap_y ? (y1 < y2) : (y2 < y1);
        n_s3_west  = swap_x ? (x1 < x2) : (x2 < x1);
        n_s3_pdy   = PW'(dyh) * PW'(HEAD_DEN);
        n_s3_pdx   = PW'(dxh) * PW'(HEAD_NUM);
    end

    assign n_s3_rr = RR_W'(r_s2_side.radius) * (RR_W'(r_s2_side.radius) + 1'b1);

    t_side              r_s3_side;
    logic [COORD_W-1:0] r_s3_nx, r_s3_ny;
    logic [AW-1:0]      r_s3_dxw, r_s3_dyw;
    logic               r_s3_north, r_s3_west;
    logic [PW-1:0]      r_s3_pdy, r_s3_pdx;
    logic [RR_W-1:0]    r_s3_rr;

    always_ff @(posedge i_clk) begin
        if (rdy[3]) begin
            r_s3_side  <= r_s2_side;
            r_s3_nx    <= n_s3_nx;
            r_s3_ny    <= n_s3_ny;
            r_s3_dxw   <= n_s3_dxw;
            r_s3_dyw   <= n_s3_dyw;
            r_s3_north <= n_s3_north;
            r_s3_west  <= n_s3_west;
            r_s3_pdy   <= n_s3_pdy;
            r_s3_pdx   <= n_s3_pdx;
            r_s3_rr    <= n_s3_rr;
        end
    end

    // Stage 4: finish each action and clear the fields the action does not use.
    logic [DIST_W-1:0]  hex_dist;
    logic [HEAD_W-1:0]  head;
    logic [COUNT_W-1:0] count;

    always_comb begin : finish
        logic signed [AW:0] dx2;
        logic [AW:0]        sum;
        logic               main_dir;
        dx2 = signed'((AW+1)'(r_s3_dxw)) - signed'((AW+1)'(r_s3_dyw >> 1));
        sum = (AW+1)'(r_s3_dyw) + (dx2[AW] ? '0 : (AW+1)'(dx2));
        hex_dist = DIST_W'(sum >> 1);
        main_dir = r_s3_pdy > r_s3_pdx;
        if (r_s3_north) begin
            head = main_dir ? HEAD_N : (r_s3_west ? HEAD_NW : HEAD_NE);
        end else begin
            head = main_dir ? HEAD_S : (r_s3_west ? HEAD_SW : HEAD_SE);
        end
        count = COUNT_W'(r_s3_rr) + (COUNT_W'(r_s3_rr) << 1)
              + COUNT_W'(r_s3_side.include_center);
    end

    logic [COORD_W-1:0] n_out_nx, n_out_ny;
    logic [DIST_W-1:0]  n_out_dist;
    logic [HEAD_W-1:0]  n_out_head;
    logic [COUNT_W-1:0] n_out_count;

    // Only the fields of the requested action carry a value; the rest are zero.
    always_comb begin : select_out
        n_out_nx    = '0;
        n_out_ny    = '0;
        n_out_dist  = '0;
        n_out_head  = '0;
        n_out_count = '0;
        unique case (r_s3_side.action)
            ACT_NEIGHBOUR: begin
                n_out_nx = r_s3_nx;
                n_out_ny = r_s3_ny;
            end
            ACT_DISTANCE: n_out_dist  = hex_dist;
            ACT_HEADING:  n_out_head  = head;
            ACT_COUNT:    n_out_count = count;
            default: ;
        endcase
    end

    logic [COORD_W-1:0] r_out_nx, r_out_ny;
    logic [DIST_W-1:0]  r_out_dist;
    logic [HEAD_W-1:0]  r_out_head;
    logic [COUNT_W-1:0] r_out_count;

    always_ff @(posedge i_clk) begin
        if (rdy[4]) begin
            r_out_nx    <= n_out_nx;
            r_out_ny    <= n_out_ny;
            r_out_dist  <= n_out_dist;
            r_out_head  <= n_out_head;
            r_out_count <= n_out_count;
        end
    end

    assign m_axis_tdata = {r_out_count, r_out_head, r_out_dist, r_out_ny, r_out_nx};

endmodule

`default_nettype wire

// ===== rtl/core/whg_rem_unit.sv =====
// Restoring remainder steps: shifts in STEPS coordinate bits and reduces by the map size.
`default_nettype none

module whg_rem_unit
    import whg_pkg::*;
#(
    parameter int SW    = CFG_W,
    parameter int STEPS = COORD_W / 2
) (
    input  logic [SW-1:0]    i_rem,
    input  logic [STEPS-1:0] i_bits,
    input  logic [SW-1:0]    i_div,
    output logic [SW-1:0]    o_rem
);

    // The partial remainder stays below the divisor, so one compare and
    // subtract per bit is enough.
    always_comb begin : rem_steps
        logic [SW:0]   t;
        logic [SW-1:0] r;
        r = i_rem;
        t = '0;
        for (int i = STEPS - 1; i >= 0; i--) begin
            t = {r, i_bits[i]};
            if (t >= {1'b0, i_div}) begin
                t = t - {1'b0, i_div};
            end
            r = t[SW-1:0];
        end
        o_rem = r;
    end

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking stream testbench for the wrapped hex grid geometry unit.

module testbench;
    import whg_pkg::*;

    // Quiet cycles after the last answer, to let the pipeline run dry
    // before a register write.
    localparam int SETTLE_CYCLES = 12;
    // Watchdog limit on the length of a run.
    localparam int CYCLE_LIMIT   = 100000;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 107;
    localparam int PRINT_CAP     = 100;

    // One geometry query as it enters the block.
    typedef struct packed {
        logic [ACT_W-1:0]    action;
        logic [COORD_W-1:0]  first_x;
        logic [COORD_W-1:0]  first_y;
        logic [COORD_W-1:0]  second_x;
        logic [COORD_W-1:0]  second_y;
        logic [DIR_W-1:0]    step_dir;
        logic [RADIUS_W-1:0] radius;
        logic                include_center;
    } t_query;

    // One answer as it leaves the block.
    typedef struct packed {
        logic [COORD_W-1:0] near_x;
        logic [COORD_W-1:0] near_y;
        logic [DIST_W-1:0]  hex_distance;
        logic [HEAD_W-1:0]  heading;
        logic [COUNT_W-1:0] cell_count;
    } t_answer;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr = '0;
    logic [CFG_W-1:0]      i_cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [ACT_W-1:0]      s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_axis_tdata;

    // Our own copy of the two map size registers, as last written.
    logic [CFG_W-1:0] map_width_reg  = MAP_RESET;
    logic [CFG_W-1:0] map_height_reg = MAP_RESET;

    t_query  queued_queries[$];
    t_answer awaited_answers[$];
    t_query  query_in_flight;
    t_answer answer_seen;
    t_answer answer_due;
    int      mismatch_count = 0;
    int      cycle_count = 0;
    // While set, neither side of the stream inserts gaps or stalls.
    bit      steady = 1'b0;

    wrapped_hex_grid_geometry dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Effective number of columns: zero counts as one, large values saturate.
    function automatic int map_cols();
        int w = int'(map_width_reg);
        if (w < 1) w = 1;
        if (w > MAX_SIDE_DEF) w = MAX_SIDE_DEF;
        return w;
    endfunction

    // Effective number of rows: always even, between 2 and the largest even side.
    function automatic int map_rows();
        int h = int'(map_height_reg) & ~1;
        int top = MAX_SIDE_DEF & ~1;
        if (h > top) h = top;
        if (h < 2) h = 2;
        return h;
    endfunction

    // Works out the answer for one query under the current map size.
    function automatic t_answer compute_answer(t_query q);
        t_answer a;
        int w, h, x1, y1, x2, y2, xm, xp, ym, yp, dx, dy, t;
        bit odd, steep;
        longint r;
        a = '0;
        w = map_cols();
        h = map_rows();
        // Points outside the map are folded back onto it first.
        x1 = int'(q.first_x) % w;
        y1 = int'(q.first_y) % h;
        x2 = int'(q.second_x) % w;
        y2 = int'(q.second_y) % h;
        case (q.action)
            ACT_NEIGHBOUR: begin
                xm  = (x1 == 0 ? w : x1) - 1;
                xp  = (x1 + 1 == w) ? 0 : x1 + 1;
                ym  = (y1 == 0 ? h : y1) - 1;
                yp  = (y1 + 1 == h) ? 0 : y1 + 1;
                odd = (y1 % 2) != 0;
                // Odd rows sit half a cell to the right, so diagonal steps
                // keep or advance the column depending on the row parity.
                case (q.step_dir)
                    DIR_W_: begin
                        a.near_x = COORD_W'(xm);
                        a.near_y = COORD_W'(y1);
                    end
                    DIR_NW: begin
                        a.near_x = COORD_W'(odd ? x1 : xm);
                        a.near_y = COORD_W'(ym);
                    end
                    DIR_NE: begin
                        a.near_x = COORD_W'(odd ? xp : x1);
                        a.near_y = COORD_W'(ym);
                    end
                    DIR_E: begin
                        a.near_x = COORD_W'(xp);
                        a.near_y = COORD_W'(y1);
                    end
                    DIR_SE: begin
                        a.near_x = COORD_W'(odd ? xp : x1);
                        a.near_y = COORD_W'(yp);
                    end
                    default: begin
                        // South-west, and also the two unused codes.
                        a.near_x = COORD_W'(odd ? x1 : xm);
                        a.near_y = COORD_W'(yp);
                    end
                endcase
            end
            ACT_DISTANCE: begin
                // Work in half cells so the row shift stays an integer.
                dx = (x1 - x2) * 2 + (y1 % 2) - (y2 % 2);
                dy = (y1 > y2 ? y1 - y2 : y2 - y1) * 2;
                if (dx < 0) dx = -dx;
                if (dy > h) dy = h * 2 - dy;
                if (dx > w) dx = w * 2 - dx;
                dx = dx - dy / 2;
                a.hex_distance = DIST_W'((dy + (dx > 0 ? dx : 0)) / 2);
            end
            ACT_HEADING: begin
                dy = y1 > y2 ? y1 - y2 : y2 - y1;
                dx = x1 > x2 ? x1 - x2 : x2 - x1;
                // Going the short way round the torus flips the sense.
                if (dy > h / 2) begin
                    dy = h - dy;
                    t = y1;
                    y1 = y2;
                    y2 = t;
                end
                if (dx > w / 2) begin
                    dx = w - dx;
                    t = x1;
                    x1 = x2;
                    x2 = t;
                end
                steep = longint'(dy) * HEAD_DEN > longint'(dx) * HEAD_NUM;
                if (y2 < y1) begin
                    a.heading = steep ? HEAD_N : (x2 < x1 ? HEAD_NW : HEAD_NE);
                end else begin
                    a.heading = steep ? HEAD_S : (x2 < x1 ? HEAD_SW : HEAD_SE);
                end
            end
            default: begin
                r = longint'(q.radius);
                a.cell_count = COUNT_W'((r * r + r) * 3 + longint'(q.include_center));
            end
        endcase
        return a;
    endfunction

    function automatic t_query make_query(logic [ACT_W-1:0] action, int fx, int fy,
                                          int sx, int sy, int dir, int radius, bit center);
        t_query q;
        q.action         = action;
        q.first_x        = COORD_W'(fx);
        q.first_y        = COORD_W'(fy);
        q.second_x       = COORD_W'(sx);
        q.second_y       = COORD_W'(sy);
        q.step_dir       = DIR_W'(dir);
        q.radius         = RADIUS_W'(radius);
        q.include_center = center;
        return q;
    endfunction

    // Coordinates lean toward the map edges, where the wrapping happens,
    // but also cover the whole field so that folding is exercised.
    function automatic logic [COORD_W-1:0] pick_coord(int side);
        case ($urandom_range(3, 0))
            0: return COORD_W'($urandom_range(1023, 0));
            1: return COORD_W'(side - 1);
            2: return '0;
            default: return COORD_W'($urandom_range(side - 1, 0));
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP) $display("MISMATCH at %0t ns: %s", $time, msg);
    endtask

    // Waits until every query has been sent and answered, then lets the
    // pipeline settle.
    task automatic wait_until_idle();
        @(negedge i_clk);
        while (queued_queries.size() != 0 || s_axis_tvalid || awaited_answers.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Register writes only happen while the block is idle, so our copy of
    // the map size can change at the same edge as the block's.
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_MAP_WIDTH) begin
            map_width_reg = value;
        end else begin
            map_height_reg = value;
        end
    endtask

    // Source side: sends queued queries, holding each one until its transfer,
    // and predicts the answer at the edge where the transfer takes place.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                awaited_answers.push_back(compute_answer(query_in_flight));
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (queued_queries.size() != 0 && (steady || $urandom_range(99, 0) >= 8)) begin
                    query_in_flight = queued_queries.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {2'b00, query_in_flight.include_center,
                                      query_in_flight.radius, query_in_flight.step_dir,
                                      query_in_flight.second_y, query_in_flight.second_x,
                                      query_in_flight.first_y, query_in_flight.first_x};
                    s_axis_tuser  <= query_in_flight.action;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Sink side: stalls at random and checks every answer against the oldest
    // prediction, field by field.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= steady || ($urandom_range(99, 0) >= 8);
            if (m_axis_tvalid && m_axis_tready) begin
                if (awaited_answers.size() == 0) begin
                    report_mismatch($sformatf("answer 0x%0h with no query waiting",
                                              m_axis_tdata));
                end else begin
                    answer_due = awaited_answers.pop_front();
                    answer_seen.near_x       = m_axis_tdata[9:0];
                    answer_seen.near_y       = m_axis_tdata[19:10];
                    answer_seen.hex_distance = m_axis_tdata[30:20];
                    answer_seen.heading      = m_axis_tdata[33:31];
                    answer_seen.cell_count   = m_axis_tdata[55:34];
                    if (answer_seen.near_x !== answer_due.near_x)
                        report_mismatch($sformatf("near_x got %0d want %0d",
                                                  answer_seen.near_x, answer_due.near_x));
                    if (answer_seen.near_y !== answer_due.near_y)
                        report_mismatch($sformatf("near_y got %0d want %0d",
                                                  answer_seen.near_y, answer_due.near_y));
                    if (answer_seen.hex_distance !== answer_due.hex_distance)
                        report_mismatch($sformatf("hex_distance got %0d want %0d",
                                                  answer_seen.hex_distance,
                                                  answer_due.hex_distance));
                    if (answer_seen.heading !== answer_due.heading)
                        report_mismatch($sformatf("heading got %0d want %0d",
                                                  answer_seen.heading, answer_due.heading));
                    if (answer_seen.cell_count !== answer_due.cell_count)
                        report_mismatch($sformatf("cell_count got %0d want %0d",
                                                  answer_seen.cell_count,
                                                  answer_due.cell_count));
                end
            end
        end
    end

    // Watchdog: a lost answer would otherwise hang the run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        logic [CFG_W-1:0] phase_w [RANDOM_PHASES];
        logic [CFG_W-1:0] phase_h [RANDOM_PHASES];
        t_query q;
        int cols;
        int rows;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed queries on the reset map of 1024 by 1024.
        // Every step direction from the corner, including the two unused codes.
        for (int d = 0; d < 8; d++) begin
            queued_queries.push_back(make_query(ACT_NEIGHBOUR, 0, 0, 0, 0, d, 0, 0));
        end
        // Steps off the far corner, which is on an odd row.
        queued_queries.push_back(make_query(ACT_NEIGHBOUR, 1023, 1023, 0, 0, DIR_E, 0, 0));
        queued_queries.push_back(make_query(ACT_NEIGHBOUR, 1023, 1023, 0, 0, DIR_SE, 0, 0));
        queued_queries.push_back(make_query(ACT_NEIGHBOUR, 1023, 1023, 0, 0, DIR_NW, 0, 0));
        // Distances across the wrap, to the far middle and to itself.
        queued_queries.push_back(make_query(ACT_DISTANCE, 0, 0, 1023, 1023, 0, 0, 0));
        queued_queries.push_back(make_query(ACT_DISTANCE, 0, 0, 512, 512, 0, 0, 0));
        queued_queries.push_back(make_query(ACT_DISTANCE, 7, 7, 7, 7, 0, 0, 0));
        // Headings: equal rows, equal columns both ways, and across the wrap.
        queued_queries.push_back(make_query(ACT_HEADING, 10, 10, 20, 10, 0, 0, 0));
        queued_queries.push_back(make_query(ACT_HEADING, 10, 10, 10, 20, 0, 0, 0));
        queued_queries.push_back(make_query(ACT_HEADING, 10, 20, 10, 10, 0, 0, 0));
        queued_queries.push_back(make_query(ACT_HEADING, 0, 0, 1023, 1023, 0, 0, 0));
        // Cell counts at the smallest and largest radius; the last one has
        // every input field at its top value.
        queued_queries.push_back(make_query(ACT_COUNT, 0, 0, 0, 0, 0, 0, 0));
        queued_queries.push_back(make_query(ACT_COUNT, 0, 0, 0, 0, 0, 0, 1));
        queued_queries.push_back(make_query(ACT_COUNT, 1023, 1023, 1023, 1023, 7, 1023, 1));

        // Map sizes per phase: out of range both ways, the smallest maps,
        // odd heights, thin maps and two random sizes.
        phase_w = '{11'd0, 11'd2047, 11'd2, 11'd13, 11'd1023,
                    11'($urandom_range(1024, 1)), 11'($urandom_range(2047, 0)), 11'd1024};
        phase_h = '{11'd0, 11'd2047, 11'd3, 11'd9, 11'd1023,
                    11'($urandom_range(1024, 2)), 11'($urandom_range(2047, 0)), 11'd2};

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            wait_until_idle();
            write_reg(CFG_MAP_WIDTH, phase_w[p]);
            write_reg(CFG_MAP_HEIGHT, phase_h[p]);
            @(negedge i_clk);
            // Two phases run back to back with no gaps on either side.
            steady = (p == 3 || p == 4);
            cols = map_cols();
            rows = map_rows();
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                q.action   = ACT_W'($urandom_range(3, 0));
                q.first_x  = pick_coord(cols);
                q.first_y  = pick_coord(rows);
                q.second_x = pick_coord(cols);
                q.second_y = pick_coord(rows);
                q.step_dir = DIR_W'($urandom_range(7, 0));
                case ($urandom_range(3, 0))
                    0: q.radius = RADIUS_W'(1023);
                    1: q.radius = RADIUS_W'($urandom_range(20, 0));
                    default: q.radius = RADIUS_W'($urandom_range(1023, 0));
                endcase
                q.include_center = 1'($urandom_range(1, 0));
                queued_queries.push_back(q);
            end
        end

        wait_until_idle();
        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
